[design/hlv_pkg.sv]
// Shared types, constants and trig table builder for the Hough line block.
package hlv_pkg;

    // Configuration register indexes
    localparam logic [1:0] CFG_RHO_BINS  = 2'd0;
    localparam logic [1:0] CFG_THRESHOLD = 2'd1;
    localparam logic [1:0] CFG_RADIUS    = 2'd2;

    // Register reset values
    localparam logic [10:0] RHO_BINS_RST  = 11'd1024;
    localparam logic [6:0]  THRESHOLD_RST = 7'd50;
    localparam logic [3:0]  RADIUS_RST    = 4'd5;

    // Percent limit and reciprocal of 100 (exact floor for products below 25600)
    localparam logic [6:0]  PCT_MAX     = 7'd100;
    localparam logic [12:0] RECIP_100   = 13'd5243;
    localparam int          RECIP_SHIFT = 19;

    localparam logic [63:0] Q30_ONE = 64'd1 << 30;
    localparam logic [63:0] PI_Q30  = 64'd3373259426;

    // Controller states
    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DRAIN,
        ST_MAX,
        ST_MAX_END,
        ST_PROD,
        ST_DIV,
        ST_SCAN_RD,
        ST_SCAN_CHK,
        ST_WIN,
        ST_WIN_END,
        ST_FLUSH
    } ctrl_state_t;

    // One reported peak
    typedef struct packed {
        logic [7:0] votes;
        logic [9:0] distance;
        logic [7:0] angle;
    } peak_t;

    // Voter status towards the controller
    typedef struct packed {
        logic active;
        logic idle;
    } vote_stat_t;

    // Taylor series for sine in Q30
    function automatic logic [63:0] sin_series(input logic [63:0] x);
        logic [63:0] x2;
        logic [63:0] t;
        x2 = (x * x) >> 30;
        t  = Q30_ONE;
        t  = Q30_ONE - ((x2 * t) >> 30) / 64'd110;
        t  = Q30_ONE - ((x2 * t) >> 30) / 64'd72;
        t  = Q30_ONE - ((x2 * t) >> 30) / 64'd42;
        t  = Q30_ONE - ((x2 * t) >> 30) / 64'd20;
        t  = Q30_ONE - ((x2 * t) >> 30) / 64'd6;
        return (x * t) >> 30;
    endfunction

    // Taylor series for cosine in Q30
    function automatic logic [63:0] cos_series(input logic [63:0] x);
        logic [63:0] x2;
        logic [63:0] t;
        x2 = (x * x) >> 30;
        t  = Q30_ONE;
        t  = Q30_ONE - ((x2 * t) >> 30) / 64'd132;
        t  = Q30_ONE - ((x2 * t) >> 30) / 64'd90;
        t  = Q30_ONE - ((x2 * t) >> 30) / 64'd56;
        t  = Q30_ONE - ((x2 * t) >> 30) / 64'd30;
        t  = Q30_ONE - ((x2 * t) >> 30) / 64'd12;
        t  = Q30_ONE - ((x2 * t) >> 30) / 64'd2;
        return t;
    endfunction

    // Q16 cosine (want_sin = 0) or sine (want_sin = 1) of k degrees
    function automatic int trig_q16(input int k, input bit want_sin);
        int          q;
        int          r;
        logic [63:0] x;
        logic [63:0] s;
        logic [63:0] c;
        int          sq;
        int          cq;
        int          cv;
        int          sv;
        q = (k / 90) % 4;
        r = k % 90;
        if (r <= 45)
        begin
            x = (64'(r) * PI_Q30 + 64'd90) / 64'd180;
            s = sin_series(x);
            c = cos_series(x);
        end
        else
        begin
            x = (64'(90 - r) * PI_Q30 + 64'd90) / 64'd180;
            s = cos_series(x);
            c = sin_series(x);
        end
        sq = int'((s + 64'd8192) >> 14);
        cq = int'((c + 64'd8192) >> 14);
        if (q == 0)
        begin
            cv = cq;
            sv = sq;
        end
        else if (q == 1)
        begin
            cv = -sq;
            sv = cq;
        end
        else if (q == 2)
        begin
            cv = -cq;
            sv = -sq;
        end
        else
        begin
            cv = sq;
            sv = -cq;
        end
        return want_sin ? sv : cv;
    endfunction

endpackage

[design/hlv_voter.sv]
// Angle sequencer: one vote address per cycle for the pixel being processed.
module hlv_voter #(
    parameter int ANGLE_BINS   = 180,
    parameter int MAX_RHO_BINS = 1024,
    localparam int T_W    = $clog2(ANGLE_BINS),
    localparam int R_W    = $clog2(MAX_RHO_BINS),
    localparam int RB_W   = $clog2(MAX_RHO_BINS + 1),
    localparam int ADDR_W = $clog2(ANGLE_BINS * MAX_RHO_BINS)
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [8:0]          x,
    input  logic [8:0]          y,
    input  logic [RB_W-1:0]     rb,
    output logic                req_valid,
    output logic [ADDR_W-1:0]   req_addr,
    output hlv_pkg::vote_stat_t stat
);

    // Constant trig tables
    logic signed [17:0] cos_tab [ANGLE_BINS];
    logic signed [17:0] sin_tab [ANGLE_BINS];

    for (genvar k = 0; k < ANGLE_BINS; k++)
    begin : g_trig
        localparam int COSV = hlv_pkg::trig_q16(k, 1'b0);
        localparam int SINV = hlv_pkg::trig_q16(k, 1'b1);
        assign cos_tab[k] = 18'(COSV);
        assign sin_tab[k] = 18'(SINV);
    end

    logic                     active_reg;
    logic [T_W-1:0]           t_reg;
    logic [8:0]               x_reg;
    logic [8:0]               y_reg;
    logic                     p1_valid_reg;
    logic signed [27:0]       pc_reg;
    logic signed [27:0]       ps_reg;
    logic [ADDR_W-1:0]        base_reg;
    logic                     req_valid_reg;
    logic [ADDR_W-1:0]        req_addr_reg;

    logic signed [28:0]       sum;
    logic [28:0]              mag;
    logic [28:0]              rnd;
    logic [12:0]              r_full;
    logic [12:0]              rb_m1;
    logic [12:0]              r_sel;

    // Rounded magnitude, clamped to the last bin in use
    always_comb
    begin
        sum    = 29'(pc_reg) + 29'(ps_reg);
        mag    = sum[28] ? 29'(-sum) : 29'(sum);
        rnd    = mag + 29'd32768;
        r_full = rnd[28:16];
        rb_m1  = 13'(rb) - 13'd1;
        r_sel  = (r_full > rb_m1) ? rb_m1 : r_full;
    end

    // Angle counter and two pipeline stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg    <= 1'b0;
            t_reg         <= '0;
            p1_valid_reg  <= 1'b0;
            req_valid_reg <= 1'b0;
        end
        else
        begin
            if (start)
            begin
                active_reg <= 1'b1;
                t_reg      <= '0;
            end
            else if (active_reg)
            begin
                if (t_reg == T_W'(ANGLE_BINS - 1))
                    active_reg <= 1'b0;
                else
                    t_reg <= t_reg + 1'b1;
            end
            p1_valid_reg  <= active_reg;
            req_valid_reg <= p1_valid_reg;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            x_reg <= x;
            y_reg <= y;
        end
        pc_reg       <= $signed({1'b0, x_reg}) * cos_tab[t_reg];
        ps_reg       <= $signed({1'b0, y_reg}) * sin_tab[t_reg];
        base_reg     <= ADDR_W'(t_reg) * ADDR_W'(MAX_RHO_BINS);
        req_addr_reg <= base_reg + ADDR_W'(r_sel[R_W-1:0]);
    end

    assign req_valid   = req_valid_reg;
    assign req_addr    = req_addr_reg;
    assign stat.active = active_reg;
    assign stat.idle   = !active_reg && !p1_valid_reg && !req_valid_reg;

endmodule

[design/hlv_peak_out.sv]
// Peak buffer: collects a frame's peaks, then sends them with last and truncated marks.
module hlv_peak_out #(
    parameter int MAX_PEAKS = 64,
    localparam int IDX_W = (MAX_PEAKS > 1) ? $clog2(MAX_PEAKS) : 1,
    localparam int CNT_W = $clog2(MAX_PEAKS + 1)
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               wr_en,
    input  logic [IDX_W-1:0]   wr_idx,
    input  hlv_pkg::peak_t     wr_peak,
    input  logic               flush,
    input  logic [CNT_W-1:0]   flush_count,
    input  logic               flush_trunc,
    output logic               out_valid,
    input  logic               out_ready,
    output hlv_pkg::peak_t     out_peak,
    output logic               out_last,
    output logic               out_trunc,
    output logic               busy
);

    hlv_pkg::peak_t     buf_mem [MAX_PEAKS];
    hlv_pkg::peak_t     rd_data_reg;
    logic               busy_reg;
    logic [CNT_W-1:0]   n_reg;
    logic [CNT_W-1:0]   idx_reg;
    logic               trunc_reg;
    logic               rd_pend_reg;
    logic               pend_last_reg;
    logic               out_valid_reg;
    logic               out_last_reg;
    hlv_pkg::peak_t     out_peak_reg;
    logic               fetch;

    assign fetch = busy_reg && !out_valid_reg && !rd_pend_reg && (idx_reg < n_reg);

    // Buffer memory, registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
            buf_mem[wr_idx] <= wr_peak;
        if (fetch)
            rd_data_reg <= buf_mem[idx_reg[IDX_W-1:0]];
    end

    // Send sequencer: fetch, load, wait for the word to be taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            n_reg         <= '0;
            idx_reg       <= '0;
            trunc_reg     <= 1'b0;
            rd_pend_reg   <= 1'b0;
            pend_last_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            out_last_reg  <= 1'b0;
        end
        else
        begin
            if (flush)
            begin
                busy_reg  <= (flush_count != '0);
                n_reg     <= flush_count;
                idx_reg   <= '0;
                trunc_reg <= flush_trunc;
            end
            if (fetch)
            begin
                rd_pend_reg   <= 1'b1;
                pend_last_reg <= (idx_reg == n_reg - 1'b1);
            end
            if (rd_pend_reg)
            begin
                out_valid_reg <= 1'b1;
                out_last_reg  <= pend_last_reg;
                rd_pend_reg   <= 1'b0;
                idx_reg       <= idx_reg + 1'b1;
            end
            if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
                if (out_last_reg)
                    busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_pend_reg)
            out_peak_reg <= rd_data_reg;
    end

    assign out_valid = out_valid_reg;
    assign out_peak  = out_peak_reg;
    assign out_last  = out_last_reg;
    assign out_trunc = trunc_reg;
    assign busy      = busy_reg;

endmodule

[design/hough_line_vote_and_peaks.sv]
// Top level: vote accumulator memory, frame controller and peak search.
//
//  Channel   Dir  Fields (low bit up)                               Handshake
//  s_axis    in   tdata: pixel_x[8:0] pixel_y[17:9] value[25:18]    tvalid/tready, tlast=last
//  m_axis    out  tdata: angle[7:0] distance[17:8] votes[25:18]     tvalid/tready, tlast, tuser
//  cfg       in   cfg_index, cfg_data                               cfg_we, no wait
//
// A nonzero pixel holds off the next pixel while the voter steps through every angle, with
// one read-modify-write of the vote memory per angle; a zero pixel does not vote. After the
// last pixel: a max pass over the cells in use, then a scan of each cell with a window check
// of up to (2r+1)^2 cells per candidate. Every frame and reset end with a clearing pass of
// all ANGLE_BINS*MAX_RHO_BINS cells, during which no pixel is accepted. A stalled receiver
// holds peaks in the output buffer; the next frame's peak search waits until it has been sent.
module hough_line_vote_and_peaks #(
    parameter int ANGLE_BINS   = 180,
    parameter int MAX_RHO_BINS = 1024,
    parameter int MAX_PEAKS    = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // pixel_x, pixel_y, pixel_value, zero fill
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // peak_angle, peak_distance, peak_votes, zero fill
    output logic        m_axis_tlast,
    output logic [0:0]  m_axis_tuser,   // truncated
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [10:0] cfg_data
);

    localparam int T_W    = $clog2(ANGLE_BINS);
    localparam int R_W    = $clog2(MAX_RHO_BINS);
    localparam int RB_W   = $clog2(MAX_RHO_BINS + 1);
    localparam int DEPTH  = ANGLE_BINS * MAX_RHO_BINS;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int IDX_W  = (MAX_PEAKS > 1) ? $clog2(MAX_PEAKS) : 1;
    localparam int CNT_W  = $clog2(MAX_PEAKS + 1);
    localparam int RECIP_SHIFT_HI = hlv_pkg::RECIP_SHIFT + 7;

    // Configuration registers
    logic [10:0] rho_bins_reg;
    logic [6:0]  pct_reg;
    logic [3:0]  rad_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rho_bins_reg <= hlv_pkg::RHO_BINS_RST;
            pct_reg      <= hlv_pkg::THRESHOLD_RST;
            rad_reg      <= hlv_pkg::RADIUS_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                hlv_pkg::CFG_RHO_BINS:  rho_bins_reg <= cfg_data;
                hlv_pkg::CFG_THRESHOLD: pct_reg      <= cfg_data[6:0];
                hlv_pkg::CFG_RADIUS:    rad_reg      <= cfg_data[3:0];
                default: ;
            endcase
        end
    end

    // Bins in use and clamped percent
    logic [RB_W-1:0] rb_use;
    logic [12:0]     rb_m1;
    logic [6:0]      pct_use;

    always_comb
    begin
        if (rho_bins_reg == 11'd0)
            rb_use = RB_W'(1);
        else if (13'(rho_bins_reg) > 13'(MAX_RHO_BINS))
            rb_use = RB_W'(MAX_RHO_BINS);
        else
            rb_use = RB_W'(rho_bins_reg);
        rb_m1   = 13'(rb_use) - 13'd1;
        pct_use = (pct_reg > hlv_pkg::PCT_MAX) ? hlv_pkg::PCT_MAX : pct_reg;
    end

    hlv_pkg::ctrl_state_t state_reg;
    hlv_pkg::ctrl_state_t state_next;

    // Voter
    logic                pix_accept;
    logic                vote_start;
    logic                req_valid;
    logic [ADDR_W-1:0]   req_addr;
    hlv_pkg::vote_stat_t vstat;

    assign s_axis_tready = (state_reg == hlv_pkg::ST_IDLE) && !vstat.active;
    assign pix_accept    = s_axis_tvalid && s_axis_tready;
    assign vote_start    = pix_accept && (s_axis_tdata[25:18] != 8'd0);

    hlv_voter #(
        .ANGLE_BINS   (ANGLE_BINS),
        .MAX_RHO_BINS (MAX_RHO_BINS)
    ) u_voter (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (vote_start),
        .x         (s_axis_tdata[8:0]),
        .y         (s_axis_tdata[17:9]),
        .rb        (rb_use),
        .req_valid (req_valid),
        .req_addr  (req_addr),
        .stat      (vstat)
    );

    // Vote memory, one write and one registered read per cycle
    logic [7:0]        vote_mem [DEPTH];
    logic [7:0]        mem_rdata_reg;
    logic              mem_re;
    logic [ADDR_W-1:0] mem_raddr;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [7:0]        mem_wdata;

    always_ff @(posedge clk)
    begin
        if (mem_we)
            vote_mem[mem_waddr] <= mem_wdata;
        if (mem_re)
            mem_rdata_reg <= vote_mem[mem_raddr];
    end

    // Scan and window registers
    logic                rmw_valid_reg;
    logic [ADDR_W-1:0]   rmw_addr_reg;
    logic [ADDR_W-1:0]   caddr_reg;
    logic [T_W-1:0]      t_reg;
    logic [R_W-1:0]      r_reg;
    logic [ADDR_W-1:0]   base_reg;
    logic                rd_pend_reg;
    logic [7:0]          max_reg;
    logic [14:0]         prod_reg;
    logic [7:0]          thresh_reg;
    logic [7:0]          cand_reg;
    logic [T_W-1:0]      wt_reg;
    logic [R_W-1:0]      wr_reg;
    logic [ADDR_W-1:0]   wbase_reg;
    logic [T_W-1:0]      thi_reg;
    logic [R_W-1:0]      rlo_reg;
    logic [R_W-1:0]      rhi_reg;
    logic                beaten_reg;
    logic [CNT_W-1:0]    cnt_reg;
    logic                trunc_reg;

    logic                scan_last;
    logic                win_last;
    logic                beat;
    logic [12:0]         t13;
    logic [12:0]         r13;
    logic [12:0]         rad13;
    logic [12:0]         tlo13;
    logic [12:0]         thi13;
    logic [12:0]         rlo13;
    logic [12:0]         rhi13;
    logic [29:0]         div_prod;
    logic                out_busy;
    logic                buf_we;
    logic                flush;

    // Window bounds, cut at the edges of the region in use
    always_comb
    begin
        t13   = 13'(t_reg);
        r13   = 13'(r_reg);
        rad13 = 13'(rad_reg);
        tlo13 = (t13 >= rad13) ? t13 - rad13 : 13'd0;
        thi13 = (t13 + rad13 > 13'(ANGLE_BINS - 1)) ? 13'(ANGLE_BINS - 1) : t13 + rad13;
        rlo13 = (r13 >= rad13) ? r13 - rad13 : 13'd0;
        rhi13 = (r13 + rad13 > rb_m1) ? rb_m1 : r13 + rad13;
    end

    assign scan_last = (t_reg == T_W'(ANGLE_BINS - 1)) && (r13 == rb_m1);
    assign win_last  = (wt_reg == thi_reg) && (wr_reg == rhi_reg);
    assign beat      = beaten_reg || (rd_pend_reg && (mem_rdata_reg > cand_reg));
    assign div_prod  = prod_reg * hlv_pkg::RECIP_100;

    // Memory port selection
    always_comb
    begin
        mem_re    = 1'b0;
        mem_raddr = req_addr;
        mem_we    = rmw_valid_reg;
        mem_waddr = rmw_addr_reg;
        mem_wdata = (mem_rdata_reg == 8'hFF) ? 8'hFF : mem_rdata_reg + 8'd1;
        case (state_reg) inside
            hlv_pkg::ST_IDLE, hlv_pkg::ST_DRAIN:
            begin
                mem_re = req_valid;
            end
            hlv_pkg::ST_MAX, hlv_pkg::ST_SCAN_RD:
            begin
                mem_re    = 1'b1;
                mem_raddr = base_reg + ADDR_W'(r_reg);
            end
            hlv_pkg::ST_WIN:
            begin
                mem_re    = 1'b1;
                mem_raddr = wbase_reg + ADDR_W'(wr_reg);
            end
            hlv_pkg::ST_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = caddr_reg;
                mem_wdata = 8'd0;
            end
            default: ;
        endcase
    end

    // Next state and strobes
    always_comb
    begin
        state_next = state_reg;
        buf_we     = 1'b0;
        flush      = 1'b0;
        unique case (state_reg)
            hlv_pkg::ST_CLEAR:
                if (caddr_reg == ADDR_W'(DEPTH - 1))
                    state_next = hlv_pkg::ST_IDLE;
            hlv_pkg::ST_IDLE:
                if (pix_accept && s_axis_tlast)
                    state_next = hlv_pkg::ST_DRAIN;
            hlv_pkg::ST_DRAIN:
                if (vstat.idle && !rmw_valid_reg)
                    state_next = hlv_pkg::ST_MAX;
            hlv_pkg::ST_MAX:
                if (scan_last)
                    state_next = hlv_pkg::ST_MAX_END;
            hlv_pkg::ST_MAX_END:
                state_next = hlv_pkg::ST_PROD;
            hlv_pkg::ST_PROD:
                state_next = hlv_pkg::ST_DIV;
            hlv_pkg::ST_DIV:
                if (!out_busy)
                    state_next = hlv_pkg::ST_SCAN_RD;
            hlv_pkg::ST_SCAN_RD:
                state_next = hlv_pkg::ST_SCAN_CHK;
            hlv_pkg::ST_SCAN_CHK:
            begin
                if (mem_rdata_reg >= thresh_reg)
                    state_next = hlv_pkg::ST_WIN;
                else if (scan_last)
                    state_next = hlv_pkg::ST_FLUSH;
                else
                    state_next = hlv_pkg::ST_SCAN_RD;
            end
            hlv_pkg::ST_WIN:
                if (win_last)
                    state_next = hlv_pkg::ST_WIN_END;
            hlv_pkg::ST_WIN_END:
            begin
                if (!beat && (cnt_reg == CNT_W'(MAX_PEAKS)))
                    state_next = hlv_pkg::ST_FLUSH;
                else
                begin
                    buf_we     = !beat;
                    state_next = scan_last ? hlv_pkg::ST_FLUSH : hlv_pkg::ST_SCAN_RD;
                end
            end
            hlv_pkg::ST_FLUSH:
            begin
                flush      = 1'b1;
                state_next = hlv_pkg::ST_CLEAR;
            end
            default:
                state_next = hlv_pkg::ST_CLEAR;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= hlv_pkg::ST_CLEAR;
        else
            state_reg <= state_next;
    end

    // Controller datapath
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rmw_valid_reg <= 1'b0;
            caddr_reg     <= '0;
            rd_pend_reg   <= 1'b0;
            beaten_reg    <= 1'b0;
            cnt_reg       <= '0;
            trunc_reg     <= 1'b0;
            max_reg       <= '0;
        end
        else
        begin
            rmw_valid_reg <= req_valid;
            rmw_addr_reg  <= req_addr;
            rd_pend_reg   <= (state_reg == hlv_pkg::ST_MAX) || (state_reg == hlv_pkg::ST_WIN);

            // Running maximum over the max pass
            if (rd_pend_reg && (state_reg == hlv_pkg::ST_MAX || state_reg == hlv_pkg::ST_MAX_END)
                && (mem_rdata_reg > max_reg))
                max_reg <= mem_rdata_reg;

            // Beaten flag during the window pass
            if (rd_pend_reg && (state_reg == hlv_pkg::ST_WIN) && (mem_rdata_reg > cand_reg))
                beaten_reg <= 1'b1;

            // Cell counter advance shared by max pass and scan
            if ((state_reg == hlv_pkg::ST_MAX)
                || (state_reg == hlv_pkg::ST_SCAN_CHK && state_next == hlv_pkg::ST_SCAN_RD)
                || (state_reg == hlv_pkg::ST_WIN_END && state_next == hlv_pkg::ST_SCAN_RD))
            begin
                if (r13 == rb_m1)
                begin
                    r_reg    <= '0;
                    t_reg    <= t_reg + 1'b1;
                    base_reg <= base_reg + ADDR_W'(MAX_RHO_BINS);
                end
                else
                    r_reg <= r_reg + 1'b1;
            end

            unique case (state_reg)
                hlv_pkg::ST_CLEAR:
                    caddr_reg <= caddr_reg + 1'b1;
                hlv_pkg::ST_DRAIN:
                begin
                    t_reg    <= '0;
                    r_reg    <= '0;
                    base_reg <= '0;
                    max_reg  <= '0;
                end
                hlv_pkg::ST_PROD:
                    prod_reg <= 15'(max_reg) * 15'(pct_use);
                hlv_pkg::ST_DIV:
                begin
                    thresh_reg <= div_prod[RECIP_SHIFT_HI:hlv_pkg::RECIP_SHIFT];
                    t_reg      <= '0;
                    r_reg      <= '0;
                    base_reg   <= '0;
                    cnt_reg    <= '0;
                    trunc_reg  <= 1'b0;
                end
                hlv_pkg::ST_SCAN_CHK:
                begin
                    cand_reg   <= mem_rdata_reg;
                    wt_reg     <= T_W'(tlo13);
                    thi_reg    <= T_W'(thi13);
                    wr_reg     <= R_W'(rlo13);
                    rlo_reg    <= R_W'(rlo13);
                    rhi_reg    <= R_W'(rhi13);
                    wbase_reg  <= ADDR_W'(T_W'(tlo13)) * ADDR_W'(MAX_RHO_BINS);
                    beaten_reg <= 1'b0;
                end
                hlv_pkg::ST_WIN:
                begin
                    if (wr_reg == rhi_reg)
                    begin
                        wr_reg    <= rlo_reg;
                        wt_reg    <= wt_reg + 1'b1;
                        wbase_reg <= wbase_reg + ADDR_W'(MAX_RHO_BINS);
                    end
                    else
                        wr_reg <= wr_reg + 1'b1;
                end
                hlv_pkg::ST_WIN_END:
                begin
                    if (buf_we)
                        cnt_reg <= cnt_reg + 1'b1;
                    else if (state_next == hlv_pkg::ST_FLUSH && !beat)
                        trunc_reg <= 1'b1;
                end
                hlv_pkg::ST_FLUSH:
                    caddr_reg <= '0;
                default: ;
            endcase
        end
    end

    // Peak buffer and output channel
    hlv_pkg::peak_t wr_peak;
    hlv_pkg::peak_t out_peak;
    logic           out_trunc;

    assign wr_peak.angle    = 8'(t_reg);
    assign wr_peak.distance = 10'(r_reg);
    assign wr_peak.votes    = cand_reg;

    hlv_peak_out #(
        .MAX_PEAKS (MAX_PEAKS)
    ) u_peak_out (
        .clk         (clk),
        .rst_n       (rst_n),
        .wr_en       (buf_we),
        .wr_idx      (cnt_reg[IDX_W-1:0]),
        .wr_peak     (wr_peak),
        .flush       (flush),
        .flush_count (cnt_reg),
        .flush_trunc (trunc_reg),
        .out_valid   (m_axis_tvalid),
        .out_ready   (m_axis_tready),
        .out_peak    (out_peak),
        .out_last    (m_axis_tlast),
        .out_trunc   (out_trunc),
        .busy        (out_busy)
    );

    assign m_axis_tdata = {6'd0, out_peak.votes, out_peak.distance, out_peak.angle};
    assign m_axis_tuser = out_trunc;

    // Vote write-back never hits the cell being read in the same cycle
    a_rmw_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        (rmw_valid_reg && req_valid) |-> (rmw_addr_reg != req_addr))
        else $error("vote read and write-back on the same cell");

    // No memory reads during the clearing pass
    a_clear_no_read: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == hlv_pkg::ST_CLEAR) |-> !mem_re)
        else $error("memory read during clearing pass");

    // Peak buffer is never written while it is still being sent
    a_buf_free: assert property (@(posedge clk) disable iff (!rst_n)
        buf_we |-> (!out_busy && cnt_reg < CNT_W'(MAX_PEAKS)))
        else $error("peak buffer written while busy or full");

    // Peak search starts only after voting has drained
    a_max_after_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == hlv_pkg::ST_MAX) |-> (vstat.idle && !rmw_valid_reg))
        else $error("peak search started with votes in flight");

endmodule

[tb/tb_hough_line_vote_and_peaks.sv]
// Testbench for the Hough line vote and peak search block, checked against an in-bench predictor.
module tb_hough_line_vote_and_peaks;

    localparam int ANGLE_N    = 180;
    localparam int RHO_MAX    = 1024;
    localparam int PEAK_LIMIT = 64;
    // clearing pass after reset and after every frame, plus margin
    localparam int CLEAR_WAIT = ANGLE_N * RHO_MAX + 2000;

    typedef struct packed {
        logic [7:0] angle;
        logic [9:0] distance;
        logic [7:0] votes;
        logic       last;
        logic       trunc;
    } peak_word_t;

    typedef struct packed {
        logic [8:0] x;
        logic [8:0] y;
        logic [7:0] value;
        logic       last;
    } pixel_word_t;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata;
    logic        s_axis_tlast;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;
    logic        m_axis_tlast;
    logic [0:0]  m_axis_tuser;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [10:0] cfg_data;

    hough_line_vote_and_peaks i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    // Predictor state
    logic [7:0]  vote_mem [ANGLE_N*RHO_MAX];
    int          cos_tab [ANGLE_N];
    int          sin_tab [ANGLE_N];
    logic [10:0] rho_reg;
    logic [6:0]  pct_reg;
    logic [3:0]  rad_reg;
    peak_word_t  peak_q [$];

    int          fail_cnt;
    int          snd_idle;
    int          rcv_stall;
    int          hold_left;

    // Directed frame: extremes of every field, a zero pixel, last pixel voting
    pixel_word_t directed_rows [12] = '{
        '{9'd0,   9'd0,   8'd255, 1'b0},
        '{9'd511, 9'd511, 8'd1,   1'b0},
        '{9'd511, 9'd0,   8'd128, 1'b0},
        '{9'd0,   9'd511, 8'd64,  1'b0},
        '{9'd100, 9'd200, 8'd0,   1'b0},
        '{9'd100, 9'd100, 8'd7,   1'b0},
        '{9'd100, 9'd100, 8'd7,   1'b0},
        '{9'd100, 9'd100, 8'd7,   1'b0},
        '{9'd256, 9'd128, 8'd170, 1'b0},
        '{9'd255, 9'd383, 8'd85,  1'b0},
        '{9'd1,   9'd2,   8'd3,   1'b0},
        '{9'd100, 9'd100, 8'd200, 1'b1}
    };

    // Q30 sine and cosine series over [0, 45] degrees
    function automatic longint unsigned sine_q30(longint unsigned a);
        longint unsigned a2;
        longint unsigned t;
        a2 = (a * a) >> 30;
        t  = 64'd1 << 30;
        t  = (64'd1 << 30) - ((a2 * t) >> 30) / 110;
        t  = (64'd1 << 30) - ((a2 * t) >> 30) / 72;
        t  = (64'd1 << 30) - ((a2 * t) >> 30) / 42;
        t  = (64'd1 << 30) - ((a2 * t) >> 30) / 20;
        t  = (64'd1 << 30) - ((a2 * t) >> 30) / 6;
        return (a * t) >> 30;
    endfunction

    function automatic longint unsigned cosine_q30(longint unsigned a);
        longint unsigned a2;
        longint unsigned t;
        a2 = (a * a) >> 30;
        t  = 64'd1 << 30;
        t  = (64'd1 << 30) - ((a2 * t) >> 30) / 132;
        t  = (64'd1 << 30) - ((a2 * t) >> 30) / 90;
        t  = (64'd1 << 30) - ((a2 * t) >> 30) / 56;
        t  = (64'd1 << 30) - ((a2 * t) >> 30) / 30;
        t  = (64'd1 << 30) - ((a2 * t) >> 30) / 12;
        t  = (64'd1 << 30) - ((a2 * t) >> 30) / 2;
        return t;
    endfunction

    // Q16 trig tables with quadrant symmetry
    task automatic fill_trig_tables();
        longint unsigned a;
        longint unsigned sv;
        longint unsigned cv;
        int              quad;
        int              rem;
        int              sq;
        int              cq;
        for (int k = 0; k < ANGLE_N; k++)
        begin
            quad = (k / 90) % 4;
            rem  = k % 90;
            if (rem <= 45)
            begin
                a  = (longint'(rem) * 64'd3373259426 + 90) / 180;
                sv = sine_q30(a);
                cv = cosine_q30(a);
            end
            else
            begin
                a  = (longint'(90 - rem) * 64'd3373259426 + 90) / 180;
                sv = cosine_q30(a);
                cv = sine_q30(a);
            end
            sq = int'((sv + 8192) >> 14);
            cq = int'((cv + 8192) >> 14);
            case (quad)
                0: begin cos_tab[k] = cq;  sin_tab[k] = sq;  end
                1: begin cos_tab[k] = -sq; sin_tab[k] = cq;  end
                2: begin cos_tab[k] = -cq; sin_tab[k] = -sq; end
                default: begin cos_tab[k] = sq; sin_tab[k] = -cq; end
            endcase
        end
    endtask

    function automatic int rho_in_use();
        if (rho_reg == 0)
            return 1;
        if (rho_reg > RHO_MAX)
            return RHO_MAX;
        return int'(rho_reg);
    endfunction

    function automatic bit cell_beaten(int t, int r, int rb, int rad, logic [7:0] v);
        for (int tt = t - rad; tt <= t + rad; tt++)
        begin
            if (tt < 0 || tt >= ANGLE_N)
                continue;
            for (int rr = r - rad; rr <= r + rad; rr++)
            begin
                if (rr < 0 || rr >= rb)
                    continue;
                if (vote_mem[tt*RHO_MAX + rr] > v)
                    return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    // Vote one accepted pixel and, on the last one, queue the frame's peaks
    task automatic vote_and_search(pixel_word_t px);
        int          rb;
        longint      acc;
        longint      rbin;
        int          gmax;
        int          thresh;
        int          pct;
        int          found;
        bit          trunc;
        peak_word_t  pk;
        peak_word_t  list [$];
        rb = rho_in_use();
        if (px.value != 0)
        begin
            for (int t = 0; t < ANGLE_N; t++)
            begin
                acc = longint'(px.x) * cos_tab[t] + longint'(px.y) * sin_tab[t];
                if (acc < 0)
                    acc = -acc;
                rbin = (acc + 32768) >>> 16;
                if (rbin > rb - 1)
                    rbin = rb - 1;
                if (vote_mem[t*RHO_MAX + int'(rbin)] != 8'd255)
                    vote_mem[t*RHO_MAX + int'(rbin)]++;
            end
        end
        if (!px.last)
            return;
        gmax = 0;
        for (int t = 0; t < ANGLE_N; t++)
            for (int r = 0; r < rb; r++)
                if (vote_mem[t*RHO_MAX + r] > gmax)
                    gmax = vote_mem[t*RHO_MAX + r];
        pct    = (pct_reg > 100) ? 100 : int'(pct_reg);
        thresh = (gmax * pct) / 100;
        trunc  = 1'b0;
        found  = 0;
        for (int t = 0; t < ANGLE_N && !trunc; t++)
        begin
            for (int r = 0; r < rb; r++)
            begin
                if (vote_mem[t*RHO_MAX + r] < thresh)
                    continue;
                if (cell_beaten(t, r, rb, int'(rad_reg), vote_mem[t*RHO_MAX + r]))
                    continue;
                if (found >= PEAK_LIMIT)
                begin
                    trunc = 1'b1;
                    break;
                end
                pk.angle    = t[7:0];
                pk.distance = r[9:0];
                pk.votes    = vote_mem[t*RHO_MAX + r];
                pk.last     = 1'b0;
                pk.trunc    = 1'b0;
                list        = {list, pk};
                found++;
            end
        end
        foreach (list[k])
        begin
            list[k].trunc = trunc;
            list[k].last  = (k == list.size() - 1);
            peak_q        = {peak_q, list[k]};
        end
        foreach (vote_mem[k])
            vote_mem[k] = 8'd0;
    endtask

    // Clock
    initial
    begin
        clk = 1'b0;
        forever
            #1 clk = ~clk;
    end

    // Overall time limit
    initial
    begin
        #60000000;
        $display("[FAIL] regression broken");
        $finish;
    end

    // Receiver: random stalls, with an optional long hold-off
    initial
    begin
        m_axis_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                m_axis_tready <= 1'b0;
                hold_left--;
            end
            else
                m_axis_tready <= ($urandom_range(99) >= rcv_stall);
        end
    end

    // Result checking against the oldest expected peak
    always @(posedge clk)
    begin
        peak_word_t exp_pk;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (peak_q.size() == 0)
            begin
                $error("unexpected peak word %h", m_axis_tdata);
                fail_cnt++;
            end
            else
            begin
                exp_pk = peak_q.pop_front();
                if (m_axis_tdata[7:0] !== exp_pk.angle)
                begin
                    $error("peak_angle exp %0d got %0d", exp_pk.angle, m_axis_tdata[7:0]);
                    fail_cnt++;
                end
                if (m_axis_tdata[17:8] !== exp_pk.distance)
                begin
                    $error("peak_distance exp %0d got %0d", exp_pk.distance,
                           m_axis_tdata[17:8]);
                    fail_cnt++;
                end
                if (m_axis_tdata[25:18] !== exp_pk.votes)
                begin
                    $error("peak_votes exp %0d got %0d", exp_pk.votes, m_axis_tdata[25:18]);
                    fail_cnt++;
                end
                if (m_axis_tlast !== exp_pk.last)
                begin
                    $error("last_peak exp %0d got %0d", exp_pk.last, m_axis_tlast);
                    fail_cnt++;
                end
                if (m_axis_tuser[0] !== exp_pk.trunc)
                begin
                    $error("truncated exp %0d got %0d", exp_pk.trunc, m_axis_tuser[0]);
                    fail_cnt++;
                end
            end
        end
    end

    task automatic write_reg(logic [1:0] idx, logic [10:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        cfg_we    <= 1'b0;
        case (idx)
            hlv_pkg::CFG_RHO_BINS:  rho_reg = val;
            hlv_pkg::CFG_THRESHOLD: pct_reg = val[6:0];
            hlv_pkg::CFG_RADIUS:    rad_reg = val[3:0];
            default: ;
        endcase
    endtask

    // Offer one pixel word, with random sender gaps
    task automatic send_pixel(pixel_word_t px);
        @(negedge clk);
        while ($urandom_range(99) < snd_idle)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {6'd0, px.value, px.y, px.x};
        s_axis_tlast  <= px.last;
        do
            @(posedge clk);
        while (!s_axis_tready);
        vote_and_search(px);
    endtask

    // Wait for every peak, then for the clearing pass
    task automatic drain_frame();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (peak_q.size() != 0)
            @(posedge clk);
        repeat (CLEAR_WAIT) @(posedge clk);
    endtask

    task automatic set_phase(int ph);
        case (ph % 4)
            0: begin snd_idle = 0;  rcv_stall = 0;  end
            1: begin snd_idle = 87; rcv_stall = 0;  end
            2: begin snd_idle = 0;  rcv_stall = 87; end
            default: begin snd_idle = 23; rcv_stall = 23; end
        endcase
    endtask

    initial
    begin
        pixel_word_t px;
        int          n_pix;
        int          pct_pick;
        fail_cnt      = 0;
        snd_idle      = 0;
        rcv_stall     = 0;
        hold_left     = 0;
        rho_reg       = hlv_pkg::RHO_BINS_RST;
        pct_reg       = hlv_pkg::THRESHOLD_RST;
        rad_reg       = hlv_pkg::RADIUS_RST;
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tlast  = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = hlv_pkg::CFG_RHO_BINS;
        cfg_data      = '0;
        foreach (vote_mem[k])
            vote_mem[k] = 8'd0;
        fill_trig_tables();
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        repeat (CLEAR_WAIT) @(posedge clk);

        // Directed frame: rho above the maximum, full percent, widest window
        write_reg(hlv_pkg::CFG_RHO_BINS, 11'd2047);
        write_reg(hlv_pkg::CFG_THRESHOLD, 11'd100);
        write_reg(hlv_pkg::CFG_RADIUS, 11'd15);
        foreach (directed_rows[k])
        begin
            set_phase(k);
            send_pixel(directed_rows[k]);
        end
        drain_frame();

        // Empty frame: zero rho acts as one, percent above 100, no window,
        // the receiver holds off for a long stretch
        write_reg(hlv_pkg::CFG_RHO_BINS, 11'd0);
        write_reg(hlv_pkg::CFG_THRESHOLD, 11'd127);
        write_reg(hlv_pkg::CFG_RADIUS, 11'd0);
        set_phase(0);
        hold_left = 4000;
        px = '{9'd511, 9'd511, 8'd0, 1'b1};
        send_pixel(px);
        drain_frame();

        // Random frames with small rho ranges
        for (int f = 0; f < 3; f++)
        begin
            pct_pick = (f == 0) ? 0 : $urandom_range(0, 100);
            write_reg(hlv_pkg::CFG_RHO_BINS, 11'($urandom_range(1, 64)));
            write_reg(hlv_pkg::CFG_THRESHOLD, 11'(pct_pick));
            write_reg(hlv_pkg::CFG_RADIUS, 11'((pct_pick < 20) ? $urandom_range(0, 1)
                                                               : $urandom_range(0, 15)));
            if (f == 1)
                hold_left = 6000;
            n_pix = $urandom_range(115, 130);
            for (int k = 0; k < n_pix; k++)
            begin
                set_phase(k / 30 + f);
                px.x     = 9'($urandom_range(0, 511));
                px.y     = 9'($urandom_range(0, 511));
                px.value = ($urandom_range(9) == 0) ? 8'd0 : 8'($urandom_range(1, 255));
                px.last  = (k == n_pix - 1);
                send_pixel(px);
            end
            drain_frame();
        end

        if (fail_cnt == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
